>>> design/schmitt_gate_duration_timer_unit_assert.svh
// Assertion macros for the schmitt gate duration timer unit.
// Users must have clk and rst_n in scope.
`ifndef SCHMITT_GATE_DURATION_TIMER_UNIT_ASSERT_SVH
`define SCHMITT_GATE_DURATION_TIMER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked only outside reset
`define SGDT_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sgdt: assertion failed");

// checked during reset as well
`define SGDT_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
    else $error("sgdt: assertion failed");

`else

`define SGDT_ASSERT(label, prop)
`define SGDT_ASSERT_ALWAYS(label, prop)

`endif

`endif

>>> design/sgdt_pkg.sv
package sgdt_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int TIMER_BITS  = 24;
    localparam int COUNT_BITS  = 32;
    localparam int EDGE_BITS   = 16;
    localparam int NPULSE_BITS = 4;
    localparam int SUM_BITS    = 48;
    localparam int CFG_DATA_BITS  = 24;
    localparam int CFG_INDEX_BITS = 3;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD_LEVEL = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HYSTERESIS      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HOLDOFF_TICKS   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PULSE_LENGTH    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PULSE_COUNT     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPACING_TICKS   = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EDGE_PULSE      = 3'd6;

    // reset values of the registers
    localparam logic signed [SAMPLE_BITS-1:0] THRESHOLD_RST = 16'sd0;
    localparam logic signed [SAMPLE_BITS-1:0] HYSTERESIS_RST = 16'sd2731;
    localparam logic [TIMER_BITS-1:0]  HOLDOFF_RST  = 24'd4800;
    localparam logic [TIMER_BITS-1:0]  PULSE_LEN_RST = 24'd480;
    localparam logic [NPULSE_BITS-1:0] PULSE_CNT_RST = 4'd0;
    localparam logic [TIMER_BITS-1:0]  SPACING_RST  = 24'd4800;
    localparam logic [EDGE_BITS-1:0]   EDGE_LEN_RST = 16'd48;

    localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] cmp_sample;
        logic signed [SAMPLE_BITS-1:0] bias_sample;
        logic                          ext_gate;
        logic                          clear_stats;
        logic                          manual_level;
    } in_t;

    typedef struct packed {
        logic                          over;
        logic                          rising_edge;
        logic                          falling_edge;
        logic                          train_pulse;
        logic                          meas_done;
        logic [COUNT_BITS-1:0]         duration;
        logic [COUNT_BITS-1:0]         duration_min;
        logic [COUNT_BITS-1:0]         duration_max;
        logic [COUNT_BITS-1:0]         meas_total;
        logic signed [SAMPLE_BITS-1:0] bias_low;
        logic signed [SAMPLE_BITS-1:0] bias_high;
        logic signed [SUM_BITS-1:0]    bias_total;
    } out_t;

endpackage

>>> design/schmitt_gate_duration_timer_unit.sv
// Schmitt gate duration timer.
// Input channel (in_valid / in_stall / in_data): one transaction is one sample
// tick carrying the comparator and bias samples, the external gate, the clear
// request and the manual trigger level.
// Output channel (out_valid / out_stall / out_data): one transaction per input
// tick with comparator state, edge and done pulses, window duration, duration
// min/max/count and bias min/max/sum of the current or last window.
// Config port (cfg_write / cfg_index / cfg_data): register write, one per
// clock, no read-back; write only while no tick is in flight.
// The result of a tick is in the output register on the clock after it is
// accepted. Throughput is one tick per cycle while out_stall is low, set by the
// single state update that sits between the input and the output register.
// The output register holds its transaction while out_stall is high; a new
// tick is accepted whenever that register is empty or being emptied, so
// in_stall follows out_stall only while a result is waiting.
// Reset clears all state but the output data register and loads the default register values.
`include "schmitt_gate_duration_timer_unit_assert.svh"

module schmitt_gate_duration_timer_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  sgdt_pkg::in_t                          in_data,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output sgdt_pkg::out_t                         out_data,
    input  logic                                   cfg_write,
    input  logic [sgdt_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [sgdt_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    localparam logic [1:0] TRAIN_IDLE    = 2'd0;
    localparam logic [1:0] TRAIN_HOLDOFF = 2'd1;
    localparam logic [1:0] TRAIN_ACTIVE  = 2'd2;
    localparam logic [1:0] TRAIN_SPACING = 2'd3;

    localparam int SB = sgdt_pkg::SAMPLE_BITS;
    localparam int TB = sgdt_pkg::TIMER_BITS;
    localparam int CB = sgdt_pkg::COUNT_BITS;
    localparam int EB = sgdt_pkg::EDGE_BITS;
    localparam int NB = sgdt_pkg::NPULSE_BITS;
    localparam int WB = sgdt_pkg::SUM_BITS;

    // configuration
    logic signed [SB-1:0] thr_level_reg;
    logic signed [SB-1:0] hyst_reg;
    logic [TB-1:0]        holdoff_len_reg;
    logic [TB-1:0]        pulse_len_reg;
    logic [NB-1:0]        pulse_cnt_reg;
    logic [TB-1:0]        spacing_len_reg;
    logic [EB-1:0]        edge_len_reg;

    // state
    logic                 gate_reg, gate_next;
    logic [EB-1:0]        rise_reg, rise_next;
    logic [EB-1:0]        fall_reg, fall_next;
    logic                 window_reg, window_next;
    logic                 clear_hold_reg, clear_hold_next;
    logic [CB-1:0]        run_reg, run_next;
    logic signed [SB-1:0] bias_min_reg, bias_min_next;
    logic signed [SB-1:0] bias_max_reg, bias_max_next;
    logic signed [WB-1:0] bias_sum_reg, bias_sum_next;
    logic [CB-1:0]        dur_min_reg, dur_min_next;
    logic                 dur_min_valid_reg, dur_min_valid_next;
    logic [CB-1:0]        dur_max_reg, dur_max_next;
    logic [CB-1:0]        meas_cnt_reg, meas_cnt_next;
    logic [1:0]           train_state_reg, train_state_next;
    logic [NB-1:0]        train_cnt_reg, train_cnt_next;
    logic [TB-1:0]        holdoff_reg, holdoff_next;
    logic [TB-1:0]        pulse_reg, pulse_next;
    logic [TB-1:0]        spacing_reg, spacing_next;
    logic                 manual_reg, manual_next;

    logic                 out_valid_reg;
    sgdt_pkg::out_t       out_data_reg, out_data_next;

    logic                 in_fire;

    assign in_stall  = out_valid_reg & out_stall;
    assign in_fire   = in_valid & ~in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        logic signed [SB:0]   ta;
        logic signed [SB:0]   tb;
        logic signed [SB:0]   th;
        logic signed [WB:0]   sum_ext;
        logic                 rise_out;
        logic                 fall_out;
        logic                 window;
        logic                 finished;
        logic                 hold_v;
        logic                 pulse_v;
        logic                 pause_v;

        gate_next          = gate_reg;
        rise_next          = rise_reg;
        fall_next          = fall_reg;
        clear_hold_next    = clear_hold_reg;
        run_next           = run_reg;
        bias_min_next      = bias_min_reg;
        bias_max_next      = bias_max_reg;
        bias_sum_next      = bias_sum_reg;
        dur_min_next       = dur_min_reg;
        dur_min_valid_next = dur_min_valid_reg;
        dur_max_next       = dur_max_reg;
        meas_cnt_next      = meas_cnt_reg;
        train_state_next   = train_state_reg;
        train_cnt_next     = train_cnt_reg;
        holdoff_next       = holdoff_reg;
        pulse_next         = pulse_reg;
        spacing_next       = spacing_reg;
        finished           = 1'b0;

        if (in_data.clear_stats)
        begin
            run_next           = '0;
            meas_cnt_next      = '0;
            train_state_next   = TRAIN_IDLE;
            clear_hold_next    = 1'b1;
            dur_min_valid_next = 1'b0;
            dur_min_next       = '0;
            dur_max_next       = '0;
        end

        // comparator: low threshold while over, high threshold while under
        ta = (SB+1)'(thr_level_reg);
        tb = ta + (SB+1)'(hyst_reg);
        if (gate_reg)
            th = (ta >= tb) ? tb : ta;
        else
            th = (ta >= tb) ? ta : tb;
        gate_next = ((SB+1)'(in_data.cmp_sample) >= th);

        if (!gate_reg && gate_next && edge_len_reg > rise_next)
            rise_next = edge_len_reg;
        if (gate_reg && !gate_next && edge_len_reg > fall_next)
            fall_next = edge_len_reg;
        rise_out = (rise_next != '0);
        if (rise_out)
            rise_next = rise_next - EB'(1);
        fall_out = (fall_next != '0);
        if (fall_out)
            fall_next = fall_next - EB'(1);

        // measurement window
        window = in_data.ext_gate | gate_next;
        if (window && !clear_hold_next)
        begin
            if (!window_reg)
            begin
                bias_min_next = in_data.bias_sample;
                bias_max_next = in_data.bias_sample;
                bias_sum_next = '0;
                run_next      = '0;
            end
            if (run_next != '1)
                run_next = run_next + CB'(1);
            if (in_data.bias_sample < bias_min_next)
                bias_min_next = in_data.bias_sample;
            if (in_data.bias_sample > bias_max_next)
                bias_max_next = in_data.bias_sample;
            sum_ext = (WB+1)'(bias_sum_next) + (WB+1)'(in_data.bias_sample);
            if (sum_ext[WB] != sum_ext[WB-1])
                bias_sum_next = sum_ext[WB] ? sgdt_pkg::SUM_MIN : sgdt_pkg::SUM_MAX;
            else
                bias_sum_next = sum_ext[WB-1:0];
        end
        if (!window)
        begin
            if (window_reg && !clear_hold_next)
            begin
                if (run_next > dur_max_next)
                    dur_max_next = run_next;
                if (!dur_min_valid_next || run_next < dur_min_next)
                    dur_min_next = run_next;
                dur_min_valid_next = 1'b1;
                if (meas_cnt_next != '1)
                    meas_cnt_next = meas_cnt_next + CB'(1);
                finished = 1'b1;
            end
            clear_hold_next = 1'b0;
        end

        // done pulse train
        if (finished || (in_data.manual_level && !manual_reg))
        begin
            if (holdoff_len_reg > holdoff_next)
                holdoff_next = holdoff_len_reg;
            train_state_next = TRAIN_HOLDOFF;
        end
        if (pulse_cnt_reg == '0 || window)
        begin
            train_state_next = TRAIN_IDLE;
            holdoff_next     = '0;
            pulse_next       = '0;
            spacing_next     = '0;
        end
        hold_v = (holdoff_next != '0);
        if (hold_v)
            holdoff_next = holdoff_next - TB'(1);
        pulse_v = (pulse_next != '0);
        if (pulse_v)
            pulse_next = pulse_next - TB'(1);
        pause_v = (spacing_next != '0);
        if (pause_v)
            spacing_next = spacing_next - TB'(1);

        case (train_state_next)
            TRAIN_HOLDOFF:
            begin
                if (!hold_v)
                begin
                    train_state_next = TRAIN_ACTIVE;
                    if (pulse_len_reg > pulse_next)
                        pulse_next = pulse_len_reg;
                end
            end
            TRAIN_ACTIVE:
            begin
                if (!pulse_v)
                begin
                    train_cnt_next = train_cnt_next + NB'(1);
                    if (train_cnt_next >= pulse_cnt_reg)
                        train_state_next = TRAIN_IDLE;
                    else
                    begin
                        if (spacing_len_reg > spacing_next)
                            spacing_next = spacing_len_reg;
                        train_state_next = TRAIN_SPACING;
                    end
                end
            end
            TRAIN_SPACING:
            begin
                if (!pause_v)
                begin
                    if (pulse_len_reg > pulse_next)
                        pulse_next = pulse_len_reg;
                    train_state_next = TRAIN_ACTIVE;
                end
            end
            default:
            begin
                train_cnt_next = '0;
            end
        endcase

        window_next = window;
        manual_next = in_data.manual_level;

        out_data_next.over         = gate_next;
        out_data_next.rising_edge  = rise_out;
        out_data_next.falling_edge = fall_out;
        out_data_next.train_pulse  = pulse_v;
        out_data_next.meas_done    = finished;
        out_data_next.duration     = run_next;
        out_data_next.duration_min = dur_min_valid_next ? dur_min_next : '0;
        out_data_next.duration_max = dur_max_next;
        out_data_next.meas_total   = meas_cnt_next;
        out_data_next.bias_low     = bias_min_next;
        out_data_next.bias_high    = bias_max_next;
        out_data_next.bias_total   = bias_sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_level_reg   <= sgdt_pkg::THRESHOLD_RST;
            hyst_reg        <= sgdt_pkg::HYSTERESIS_RST;
            holdoff_len_reg <= sgdt_pkg::HOLDOFF_RST;
            pulse_len_reg   <= sgdt_pkg::PULSE_LEN_RST;
            pulse_cnt_reg   <= sgdt_pkg::PULSE_CNT_RST;
            spacing_len_reg <= sgdt_pkg::SPACING_RST;
            edge_len_reg    <= sgdt_pkg::EDGE_LEN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sgdt_pkg::REG_THRESHOLD_LEVEL: thr_level_reg   <= cfg_data[SB-1:0];
                sgdt_pkg::REG_HYSTERESIS:      hyst_reg        <= cfg_data[SB-1:0];
                sgdt_pkg::REG_HOLDOFF_TICKS:   holdoff_len_reg <= cfg_data[TB-1:0];
                sgdt_pkg::REG_PULSE_LENGTH:    pulse_len_reg   <= cfg_data[TB-1:0];
                sgdt_pkg::REG_PULSE_COUNT:     pulse_cnt_reg   <= cfg_data[NB-1:0];
                sgdt_pkg::REG_SPACING_TICKS:   spacing_len_reg <= cfg_data[TB-1:0];
                sgdt_pkg::REG_EDGE_PULSE:      edge_len_reg    <= cfg_data[EB-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg          <= 1'b0;
            rise_reg          <= '0;
            fall_reg          <= '0;
            window_reg        <= 1'b0;
            clear_hold_reg    <= 1'b0;
            run_reg           <= '0;
            bias_min_reg      <= '0;
            bias_max_reg      <= '0;
            bias_sum_reg      <= '0;
            dur_min_reg       <= '0;
            dur_min_valid_reg <= 1'b0;
            dur_max_reg       <= '0;
            meas_cnt_reg      <= '0;
            train_state_reg   <= TRAIN_IDLE;
            train_cnt_reg     <= '0;
            holdoff_reg       <= '0;
            pulse_reg         <= '0;
            spacing_reg       <= '0;
            manual_reg        <= 1'b0;
        end
        else if (in_fire)
        begin
            gate_reg          <= gate_next;
            rise_reg          <= rise_next;
            fall_reg          <= fall_next;
            window_reg        <= window_next;
            clear_hold_reg    <= clear_hold_next;
            run_reg           <= run_next;
            bias_min_reg      <= bias_min_next;
            bias_max_reg      <= bias_max_next;
            bias_sum_reg      <= bias_sum_next;
            dur_min_reg       <= dur_min_next;
            dur_min_valid_reg <= dur_min_valid_next;
            dur_max_reg       <= dur_max_next;
            meas_cnt_reg      <= meas_cnt_next;
            train_state_reg   <= train_state_next;
            train_cnt_reg     <= train_cnt_next;
            holdoff_reg       <= holdoff_next;
            pulse_reg         <= pulse_next;
            spacing_reg       <= spacing_next;
            manual_reg        <= manual_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            out_data_reg <= out_data_next;
    end

    // an accepted tick always lands in the output register
    `SGDT_ASSERT(a_fire_fills_out, in_fire |=> out_valid_reg)
    // no completed window means no statistics
    `SGDT_ASSERT_ALWAYS(a_stats_empty, !dur_min_valid_reg |-> (meas_cnt_reg == '0 && dur_max_reg == '0))
    // a window close is always counted
    `SGDT_ASSERT(a_done_counted, (out_valid_reg && out_data_reg.meas_done) |-> out_data_reg.meas_total != '0)
    // bias extremes stay ordered
    `SGDT_ASSERT(a_bias_order, bias_min_reg <= bias_max_reg)

endmodule

>>> verif/testbench.sv
module testbench;

    localparam int STUCK_LIMIT = 1000;

    typedef enum logic [1:0] {TR_IDLE, TR_HOLDOFF, TR_ACTIVE, TR_SPACING} train_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    sgdt_pkg::in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    sgdt_pkg::out_t out_data;
    logic cfg_write = 1'b0;
    logic [sgdt_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [sgdt_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

    schmitt_gate_duration_timer_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // pending sample ticks and the readouts they should produce
    sgdt_pkg::in_t  sample_q[$];
    sgdt_pkg::out_t readout_q[$];
    int   errors = 0;
    int   stuck_cycles = 0;
    int   in_gap = 0;
    int   stall_gap = 0;
    bit   quiet_tail = 1'b0;
    logic in_taken = 1'b0;
    sgdt_pkg::out_t want;
    sgdt_pkg::out_t predicted;

    // register copies
    logic signed [sgdt_pkg::SAMPLE_BITS-1:0] cfg_level = sgdt_pkg::THRESHOLD_RST;
    logic signed [sgdt_pkg::SAMPLE_BITS-1:0] cfg_hyst = sgdt_pkg::HYSTERESIS_RST;
    logic [sgdt_pkg::TIMER_BITS-1:0]  cfg_holdoff = sgdt_pkg::HOLDOFF_RST;
    logic [sgdt_pkg::TIMER_BITS-1:0]  cfg_plen = sgdt_pkg::PULSE_LEN_RST;
    logic [sgdt_pkg::NPULSE_BITS-1:0] cfg_npulse = sgdt_pkg::PULSE_CNT_RST;
    logic [sgdt_pkg::TIMER_BITS-1:0]  cfg_spacing = sgdt_pkg::SPACING_RST;
    logic [sgdt_pkg::EDGE_BITS-1:0]   cfg_edge = sgdt_pkg::EDGE_LEN_RST;

    // predicted block state
    logic gate = 1'b0, gate_last = 1'b0, prev_win = 1'b0, clr_hold = 1'b0;
    logic manual_last = 1'b0;
    logic [sgdt_pkg::EDGE_BITS-1:0] rise_rem = '0, fall_rem = '0;
    logic [sgdt_pkg::COUNT_BITS-1:0] run_ticks = '0, dmin = '0, dmax = '0, meas_cnt = '0;
    logic dmin_ok = 1'b0;
    logic signed [sgdt_pkg::SAMPLE_BITS-1:0] bmin = '0, bmax = '0;
    logic signed [sgdt_pkg::SUM_BITS-1:0] bsum = '0;
    train_t train_st = TR_IDLE;
    logic [sgdt_pkg::NPULSE_BITS-1:0] train_cnt = '0;
    logic [sgdt_pkg::TIMER_BITS-1:0] hold_rem = '0, pulse_rem = '0, space_rem = '0;

    function automatic sgdt_pkg::out_t tick_readout(sgdt_pkg::in_t s);
        int ta, tb, tlo, thi;
        logic win, closed, rise_on, fall_on, hold_on, pulse_on, space_on;
        longint acc;
        sgdt_pkg::out_t r;
        closed = 1'b0;
        if (s.clear_stats)
        begin
            run_ticks = '0;
            meas_cnt = '0;
            train_st = TR_IDLE;
            clr_hold = 1'b1;
            dmin_ok = 1'b0;
            dmin = '0;
            dmax = '0;
        end

        // lower threshold applies while over, upper while under
        ta = cfg_level;
        tb = ta + cfg_hyst;
        tlo = (ta >= tb) ? tb : ta;
        thi = (ta >= tb) ? ta : tb;
        gate = (int'(s.cmp_sample) >= (gate ? tlo : thi));
        if (!gate_last && gate && cfg_edge > rise_rem)
            rise_rem = cfg_edge;
        if (gate_last && !gate && cfg_edge > fall_rem)
            fall_rem = cfg_edge;
        rise_on = (rise_rem != 0);
        if (rise_on)
            rise_rem--;
        fall_on = (fall_rem != 0);
        if (fall_on)
            fall_rem--;

        win = s.ext_gate | gate;
        if (win && !clr_hold)
        begin
            if (!prev_win)
            begin
                bmin = s.bias_sample;
                bmax = s.bias_sample;
                bsum = '0;
                run_ticks = '0;
            end
            if (run_ticks != '1)
                run_ticks++;
            if (s.bias_sample < bmin)
                bmin = s.bias_sample;
            if (s.bias_sample > bmax)
                bmax = s.bias_sample;
            acc = bsum + s.bias_sample;
            if (acc > sgdt_pkg::SUM_MAX)
                bsum = sgdt_pkg::SUM_MAX;
            else if (acc < sgdt_pkg::SUM_MIN)
                bsum = sgdt_pkg::SUM_MIN;
            else
                bsum = acc[sgdt_pkg::SUM_BITS-1:0];
        end
        if (!win)
        begin
            // a window opened before a clear is dropped silently
            if (prev_win && !clr_hold)
            begin
                if (run_ticks > dmax)
                    dmax = run_ticks;
                if (!dmin_ok || run_ticks < dmin)
                    dmin = run_ticks;
                dmin_ok = 1'b1;
                if (meas_cnt != '1)
                    meas_cnt++;
                closed = 1'b1;
            end
            clr_hold = 1'b0;
        end

        if (closed || (s.manual_level && !manual_last))
        begin
            if (cfg_holdoff > hold_rem)
                hold_rem = cfg_holdoff;
            train_st = TR_HOLDOFF;
        end
        if (cfg_npulse == 0 || win)
        begin
            train_st = TR_IDLE;
            hold_rem = '0;
            pulse_rem = '0;
            space_rem = '0;
        end
        hold_on = (hold_rem != 0);
        if (hold_on)
            hold_rem--;
        pulse_on = (pulse_rem != 0);
        if (pulse_on)
            pulse_rem--;
        space_on = (space_rem != 0);
        if (space_on)
            space_rem--;

        case (train_st)
            TR_HOLDOFF:
                if (!hold_on)
                begin
                    train_st = TR_ACTIVE;
                    if (cfg_plen > pulse_rem)
                        pulse_rem = cfg_plen;
                end
            TR_ACTIVE:
                if (!pulse_on)
                begin
                    train_cnt = train_cnt + 1'b1;
                    if (train_cnt >= cfg_npulse)
                        train_st = TR_IDLE;
                    else
                    begin
                        if (cfg_spacing > space_rem)
                            space_rem = cfg_spacing;
                        train_st = TR_SPACING;
                    end
                end
            TR_SPACING:
                if (!space_on)
                begin
                    if (cfg_plen > pulse_rem)
                        pulse_rem = cfg_plen;
                    train_st = TR_ACTIVE;
                end
            default:
                train_cnt = '0;
        endcase

        gate_last = gate;
        prev_win = win;
        manual_last = s.manual_level;

        r.over = gate;
        r.rising_edge = rise_on;
        r.falling_edge = fall_on;
        r.train_pulse = pulse_on;
        r.meas_done = closed;
        r.duration = run_ticks;
        r.duration_min = dmin_ok ? dmin : '0;
        r.duration_max = dmax;
        r.meas_total = meas_cnt;
        r.bias_low = bmin;
        r.bias_high = bmax;
        r.bias_total = bsum;
        return r;
    endfunction

    task automatic check_field(string name, logic [sgdt_pkg::SUM_BITS-1:0] exp_v,
                               logic [sgdt_pkg::SUM_BITS-1:0] got_v);
        if (exp_v !== got_v)
        begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, got_v);
        end
    endtask

    // driver: new transaction or idle burst once the previous one is taken, plus random output stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (in_gap > 0)
                begin
                    in_valid <= 1'b0;
                    in_gap = in_gap - 1;
                end
                else if (!quiet_tail && $urandom_range(7) == 0)
                begin
                    in_valid <= 1'b0;
                    in_gap = $urandom_range(3);
                end
                else if (sample_q.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data <= sample_q[0];
                end
                else
                    in_valid <= 1'b0;
            end
            if (stall_gap > 0)
            begin
                out_stall <= 1'b1;
                stall_gap = stall_gap - 1;
            end
            else if (!quiet_tail && $urandom_range(7) == 0)
            begin
                out_stall <= 1'b1;
                stall_gap = $urandom_range(3);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // monitor: check results first, since a result is registered after its tick is accepted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (readout_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with nothing expected, got %h", $time, out_data);
                end
                else
                begin
                    want = readout_q.pop_front();
                    check_field("over", want.over, out_data.over);
                    check_field("rising_edge", want.rising_edge, out_data.rising_edge);
                    check_field("falling_edge", want.falling_edge, out_data.falling_edge);
                    check_field("train_pulse", want.train_pulse, out_data.train_pulse);
                    check_field("meas_done", want.meas_done, out_data.meas_done);
                    check_field("duration", want.duration, out_data.duration);
                    check_field("duration_min", want.duration_min, out_data.duration_min);
                    check_field("duration_max", want.duration_max, out_data.duration_max);
                    check_field("meas_total", want.meas_total, out_data.meas_total);
                    check_field("bias_low", want.bias_low, out_data.bias_low);
                    check_field("bias_high", want.bias_high, out_data.bias_high);
                    check_field("bias_total", want.bias_total, out_data.bias_total);
                end
            end
            if (in_valid && !in_stall)
            begin
                predicted = tick_readout(sample_q.pop_front());
                readout_q.insert(readout_q.size(), predicted);
            end
            in_taken <= in_valid && !in_stall;

            if ((sample_q.size() != 0 || readout_q.size() != 0)
                && !(in_valid && !in_stall) && !(out_valid && !out_stall))
                stuck_cycles++;
            else
                stuck_cycles = 0;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [sgdt_pkg::CFG_INDEX_BITS-1:0] idx,
                             logic [sgdt_pkg::CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            sgdt_pkg::REG_THRESHOLD_LEVEL: cfg_level = val[sgdt_pkg::SAMPLE_BITS-1:0];
            sgdt_pkg::REG_HYSTERESIS:      cfg_hyst = val[sgdt_pkg::SAMPLE_BITS-1:0];
            sgdt_pkg::REG_HOLDOFF_TICKS:   cfg_holdoff = val[sgdt_pkg::TIMER_BITS-1:0];
            sgdt_pkg::REG_PULSE_LENGTH:    cfg_plen = val[sgdt_pkg::TIMER_BITS-1:0];
            sgdt_pkg::REG_PULSE_COUNT:     cfg_npulse = val[sgdt_pkg::NPULSE_BITS-1:0];
            sgdt_pkg::REG_SPACING_TICKS:   cfg_spacing = val[sgdt_pkg::TIMER_BITS-1:0];
            sgdt_pkg::REG_EDGE_PULSE:      cfg_edge = val[sgdt_pkg::EDGE_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(logic [23:0] level, logic [23:0] hyst, logic [23:0] holdoff,
                                 logic [23:0] plen, logic [23:0] npulse, logic [23:0] spacing,
                                 logic [23:0] edge_len);
        write_reg(sgdt_pkg::REG_THRESHOLD_LEVEL, level);
        write_reg(sgdt_pkg::REG_HYSTERESIS, hyst);
        write_reg(sgdt_pkg::REG_HOLDOFF_TICKS, holdoff);
        write_reg(sgdt_pkg::REG_PULSE_LENGTH, plen);
        write_reg(sgdt_pkg::REG_PULSE_COUNT, npulse);
        write_reg(sgdt_pkg::REG_SPACING_TICKS, spacing);
        write_reg(sgdt_pkg::REG_EDGE_PULSE, edge_len);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // short timers so windows and pulse trains complete within a phase
    task automatic load_typical(bit train_off, int edge_max);
        load_settings(24'($urandom_range(6000) - 3000), 24'($urandom_range(6000) - 3000),
                      24'($urandom_range(6)), 24'($urandom_range(5)),
                      train_off ? 24'd0 : 24'($urandom_range(4, 1)), 24'($urandom_range(4)),
                      24'($urandom_range(edge_max)));
    endtask

    task automatic push_item(int cmp, int bias, bit ext, bit clr, bit man);
        sgdt_pkg::in_t it;
        it.cmp_sample = cmp[sgdt_pkg::SAMPLE_BITS-1:0];
        it.bias_sample = bias[sgdt_pkg::SAMPLE_BITS-1:0];
        it.ext_gate = ext;
        it.clear_stats = clr;
        it.manual_level = man;
        sample_q.insert(sample_q.size(), it);
    endtask

    // runs of samples above, below or inside the hysteresis band, or anywhere
    task automatic add_random_items(int n);
        int ta, tb, tlo, thi, lo, hi, v, run, kind, k;
        bit ext, man;
        sgdt_pkg::in_t it;
        k = 0;
        man = 1'b0;
        ta = cfg_level;
        tb = ta + cfg_hyst;
        tlo = (ta >= tb) ? tb : ta;
        thi = (ta >= tb) ? ta : tb;
        lo = (tlo < -32768) ? -32768 : tlo;
        hi = (thi > 32767) ? 32767 : thi;
        while (k < n)
        begin
            run = $urandom_range(12, 1);
            kind = $urandom_range(7);
            ext = ($urandom_range(9) == 0);
            repeat (run)
            begin
                v = $urandom;
                if (kind <= 2 && thi <= 32767)
                    v = thi + $urandom_range(32767 - thi);
                else if (kind >= 3 && kind <= 5 && tlo > -32768)
                    v = tlo - 1 - $urandom_range(tlo - 1 + 32768);
                else if (kind == 6 && lo <= hi)
                    v = lo + $urandom_range(hi - lo);
                it.cmp_sample = v[sgdt_pkg::SAMPLE_BITS-1:0];
                if ($urandom_range(7) == 0)
                    it.bias_sample = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
                else
                    it.bias_sample = 16'($urandom);
                it.ext_gate = (kind == 7) ? 1'($urandom_range(1)) : ext;
                it.clear_stats = ($urandom_range(59) == 0);
                if ($urandom_range(7) == 0)
                    man = ~man;
                it.manual_level = man;
                sample_q.insert(sample_q.size(), it);
                k++;
            end
        end
    endtask

    task automatic drain();
        while (sample_q.size() != 0 || readout_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // thresholds 0 and 1000, short train of two pulses
        load_settings(0, 1000, 2, 3, 2, 1, 2);
        push_item(-32768, 0, 0, 0, 0);
        push_item(32767, 32767, 0, 0, 0);
        push_item(500, -32768, 0, 0, 0);
        push_item(-1, 100, 0, 0, 0);
        repeat (8) push_item(-32768, $urandom, 0, 0, 0);
        push_item(-5, 7, 0, 0, 1);
        push_item(-5, 7, 0, 0, 1);
        push_item(-5, 7, 0, 0, 0);
        push_item(-100, -3, 1, 0, 0);
        // clear while the window is open: that window must not count
        push_item(-100, -3, 1, 1, 0);
        push_item(-100, 9, 1, 0, 0);
        push_item(-100, 9, 0, 0, 0);
        // exactly on each threshold
        push_item(1000, 1, 0, 0, 0);
        push_item(0, 2, 0, 0, 0);
        push_item(-1, 3, 0, 0, 0);
        push_item(-1, 3, 0, 1, 0);
        push_item(-1, -32768, 1, 0, 0);
        push_item(-1, 32767, 0, 0, 0);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: load_typical(1'b0, 5);
                1: load_settings(-32768, 32767, 24'hFFFFFF, 24'hFFFFFF, 15, 24'hFFFFFF,
                                 16'hFFFF);
                2: load_settings(32767, -32768, 0, 0, 15, 0, 0);
                3: load_typical(1'b1, 5);
                4: load_typical(1'b0, 40);
                default:
                begin
                    quiet_tail = 1'b1;
                    load_typical(1'b0, 8);
                end
            endcase
            add_random_items(115);
            drain();
        end

        repeat (5) @(posedge clk);
        if (errors == 0 && readout_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
